// File: hw/rtl/q_learning_table_engine_unit_assert.svh
// Assertion macros shared by the checker of the Q table engine.
// Needs a clock i_clk and an active-low reset i_rst_n in the enclosing scope.
`ifndef Q_LEARNING_TABLE_ENGINE_UNIT_ASSERT_SVH
`define Q_LEARNING_TABLE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define QLTE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qlte assertion failed");

// next-cycle implication
`define QLTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qlte assertion failed");

`endif

// File: hw/rtl/qlte_pkg.sv
// Shared types and constants of the Q table engine.
// No dependencies.
`default_nettype none

package qlte_pkg;

    localparam int QW     = 32;   // Q16.16 entry width
    localparam int CFGW   = 17;   // width of each configuration register
    localparam int LEAF_N = 8;    // leaves of the row maximum tree
    localparam int LEAF_IW = 3;   // index width into those leaves

    localparam logic [CFGW-1:0] LEARNING_RATE_RST    = 17'd6554;
    localparam logic [CFGW-1:0] DISCOUNT_FACTOR_RST  = 17'd58982;
    localparam logic [CFGW-1:0] EXPLORATION_RATE_RST = 17'd6554;

    localparam logic CMD_CHOOSE = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        CFG_LEARNING_RATE    = 2'd0,
        CFG_DISCOUNT_FACTOR  = 2'd1,
        CFG_EXPLORATION_RATE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFGW-1:0] learning_rate;
        logic [CFGW-1:0] discount_factor;
        logic [CFGW-1:0] exploration_rate;
    } t_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/qlte_cfg.sv
// APB register block for alpha, gamma and epsilon.
// Depends on qlte_pkg.
`default_nettype none

module qlte_cfg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output qlte_pkg::t_cfg        o_cfg
);

    qlte_pkg::t_cfg r_cfg;
    logic           s_wr;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learning_rate    <= qlte_pkg::LEARNING_RATE_RST;
            r_cfg.discount_factor  <= qlte_pkg::DISCOUNT_FACTOR_RST;
            r_cfg.exploration_rate <= qlte_pkg::EXPLORATION_RATE_RST;
        end else if (s_wr) begin
            case (paddr[3:2])
                qlte_pkg::CFG_LEARNING_RATE:
                    r_cfg.learning_rate <= pwdata[qlte_pkg::CFGW-1:0];
                qlte_pkg::CFG_DISCOUNT_FACTOR:
                    r_cfg.discount_factor <= pwdata[qlte_pkg::CFGW-1:0];
                qlte_pkg::CFG_EXPLORATION_RATE:
                    r_cfg.exploration_rate <= pwdata[qlte_pkg::CFGW-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            qlte_pkg::CFG_LEARNING_RATE:
                prdata = 32'(r_cfg.learning_rate);
            qlte_pkg::CFG_DISCOUNT_FACTOR:
                prdata = 32'(r_cfg.discount_factor);
            qlte_pkg::CFG_EXPLORATION_RATE:
                prdata = 32'(r_cfg.exploration_rate);
            default:
                prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/qlte_table.sv
// Q table memory: one row of all actions per word, two read ports, one write port.
// Read data is registered; no dependencies.
`default_nettype none

module qlte_table #(
    parameter int ROWS  = 256,
    parameter int AW    = 8,
    parameter int WORDW = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr_a,
    input  wire logic [AW-1:0]    i_rd_addr_b,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WORDW-1:0] i_wr_data,
    output logic      [WORDW-1:0] o_rd_data_a,
    output logic      [WORDW-1:0] o_rd_data_b
);

    logic [WORDW-1:0] r_mem [ROWS];
    logic [WORDW-1:0] r_rd_a;
    logic [WORDW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

// File: hw/rtl/qlte_rowmax.sv
// Registered maximum and argmax over one table row, lowest index on ties.
// Depends on qlte_pkg.
`default_nettype none

module qlte_rowmax #(
    parameter int ACTIONS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic [ACTIONS*qlte_pkg::QW-1:0]    i_row,
    output logic signed [qlte_pkg::QW-1:0]          o_max,
    output logic      [qlte_pkg::LEAF_IW-1:0]       o_idx
);

    localparam int QW = qlte_pkg::QW;

    logic signed [QW-1:0]               s_leaf [qlte_pkg::LEAF_N];
    logic signed [QW-1:0]               s_l1_v [4];
    logic [qlte_pkg::LEAF_IW-1:0]       s_l1_i [4];
    logic signed [QW-1:0]               s_l2_v [2];
    logic [qlte_pkg::LEAF_IW-1:0]       s_l2_i [2];
    logic signed [QW-1:0]               r_max;
    logic [qlte_pkg::LEAF_IW-1:0]       r_idx;

    // pad unused leaves with the most negative value; the left side wins ties
    always_comb begin
        for (int i = 0; i < qlte_pkg::LEAF_N; i++) begin
            if (i < ACTIONS) begin
                s_leaf[i] = i_row[i*QW +: QW];
            end else begin
                s_leaf[i] = {1'b1, {(QW-1){1'b0}}};
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (s_leaf[2*i+1] > s_leaf[2*i]) begin
                s_l1_v[i] = s_leaf[2*i+1];
                s_l1_i[i] = qlte_pkg::LEAF_IW'(2*i+1);
            end else begin
                s_l1_v[i] = s_leaf[2*i];
                s_l1_i[i] = qlte_pkg::LEAF_IW'(2*i);
            end
        end
        for (int i = 0; i < 2; i++) begin
            if (s_l1_v[2*i+1] > s_l1_v[2*i]) begin
                s_l2_v[i] = s_l1_v[2*i+1];
                s_l2_i[i] = s_l1_i[2*i+1];
            end else begin
                s_l2_v[i] = s_l1_v[2*i];
                s_l2_i[i] = s_l1_i[2*i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_l2_v[1] > s_l2_v[0]) begin
            r_max <= s_l2_v[1];
            r_idx <= s_l2_i[1];
        end else begin
            r_max <= s_l2_v[0];
            r_idx <= s_l2_i[0];
        end
    end

    assign o_max = r_max;
    assign o_idx = r_idx;

endmodule

`default_nettype wire

// File: hw/rtl/q_learning_table_engine_unit.sv
// Tabular Q-learning engine with epsilon-greedy choice. Pulse start while busy is low to
// hand over one word; its result appears on the o_ result ports for exactly one cycle with
// o_done high and cannot be held off, so take it in that cycle. A choose word registers the
// table read and then the row maximum before it gives its result; an update word registers
// the table read, the row maximum and the two multiplies (gamma * max, then alpha *
// difference) with the difference between them, followed by the saturated write-back that
// gives its result. No new word is taken before the last one gives its result. After reset
// the table is cleared one row per cycle with busy high; configuration writes are taken
// throughout.
// Depends on qlte_pkg, qlte_cfg, qlte_table and qlte_rowmax.
`default_nettype none

module q_learning_table_engine_unit #(
    parameter int STATES  = 256,
    parameter int ACTIONS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_command,
    input  wire logic [7:0]         i_state_index,
    input  wire logic [2:0]         i_action_index,
    input  wire logic signed [15:0] i_reward,
    input  wire logic [7:0]         i_next_state,
    input  wire logic [15:0]        i_random_draw,
    input  wire logic [2:0]         i_random_action,
    output logic                    o_done,
    output logic [2:0]              o_chosen_action,
    output logic                    o_explored,
    output logic signed [31:0]      o_new_q_value,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int QW    = qlte_pkg::QW;
    localparam int AW    = (STATES > 1) ? $clog2(STATES) : 1;
    localparam int ACW   = $clog2(ACTIONS);
    localparam int WORDW = ACTIONS * QW;
    localparam int GPW   = 50;  // 18 x 32 signed product
    localparam int DW    = 36;  // target - q
    localparam int APW   = 54;  // 18 x 36 signed product
    localparam int NVW   = 38;  // q + delta before saturation

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_ROW,
        S_GMUL,
        S_DIFF,
        S_AMUL,
        S_SAT
    } t_state;

    function automatic logic [AW-1:0] f_state_mod(input logic [7:0] v);
        logic [31:0] t;
        t = 32'(v);
        for (int k = 7; k >= 0; k--) begin
            if (t >= (32'(STATES) << k)) begin
                t = t - (32'(STATES) << k);
            end
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [ACW-1:0] f_action_mod(input logic [2:0] v);
        logic [31:0] t;
        t = 32'(v);
        for (int k = 2; k >= 0; k--) begin
            if (t >= (32'(ACTIONS) << k)) begin
                t = t - (32'(ACTIONS) << k);
            end
        end
        return t[ACW-1:0];
    endfunction

    t_state                         r_state;
    logic [AW-1:0]                  r_clr_addr;
    logic                           r_cmd;
    logic [AW-1:0]                  r_st;
    logic [ACW-1:0]                 r_act;
    logic [ACW-1:0]                 r_ract;
    logic signed [15:0]             r_reward;
    logic                           r_explore;
    logic signed [QW-1:0]           r_q;
    logic signed [GPW-1:0]          r_gprod;
    logic signed [DW-1:0]           r_diff;
    logic signed [APW-1:0]          r_aprod;
    logic                           r_done;
    logic [2:0]                     r_chosen;
    logic                           r_explored;
    logic signed [QW-1:0]           r_new_q;

    qlte_pkg::t_cfg                 s_cfg;
    logic                           s_accept;
    logic [AW-1:0]                  s_addr_a;
    logic [AW-1:0]                  s_addr_b;
    logic                           s_wr_en;
    logic [AW-1:0]                  s_wr_addr;
    logic [WORDW-1:0]               s_wr_data;
    logic [WORDW-1:0]               s_row_a;
    logic [WORDW-1:0]               s_row_b;
    logic signed [QW-1:0]           s_max;
    logic [qlte_pkg::LEAF_IW-1:0]   s_idx;
    logic signed [17:0]             s_gamma;
    logic signed [17:0]             s_alpha;
    logic signed [GPW-1:0]          s_gprod;
    logic signed [33:0]             s_reward_sh;
    logic signed [33:0]             s_gshift;
    logic signed [34:0]             s_target;
    logic signed [DW-1:0]           s_diff;
    logic signed [APW-1:0]          s_aprod;
    logic signed [NVW-1:0]          s_nv;
    logic signed [QW-1:0]           s_nv_sat;

    assign s_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    qlte_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    // port B feeds the row maximum: next row for update, own row for choose
    assign s_addr_a = f_state_mod(i_state_index);
    assign s_addr_b = (i_command == qlte_pkg::CMD_UPDATE) ? f_state_mod(i_next_state)
                                                          : s_addr_a;

    qlte_table #(
        .ROWS  (STATES),
        .AW    (AW),
        .WORDW (WORDW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rd_en     (s_accept),
        .i_rd_addr_a (s_addr_a),
        .i_rd_addr_b (s_addr_b),
        .i_wr_en     (s_wr_en),
        .i_wr_addr   (s_wr_addr),
        .i_wr_data   (s_wr_data),
        .o_rd_data_a (s_row_a),
        .o_rd_data_b (s_row_b)
    );

    qlte_rowmax #(
        .ACTIONS (ACTIONS)
    ) u_rowmax (
        .i_clk (i_clk),
        .i_row (s_row_b),
        .o_max (s_max),
        .o_idx (s_idx)
    );

    // fixed-point datapath; arithmetic right shifts floor toward minus infinity
    assign s_gamma     = $signed({1'b0, s_cfg.discount_factor});
    assign s_alpha     = $signed({1'b0, s_cfg.learning_rate});
    assign s_gprod     = GPW'(s_gamma) * GPW'(s_max);
    assign s_reward_sh = $signed({{2{r_reward[15]}}, r_reward, 16'd0});
    assign s_gshift    = r_gprod[GPW-1:16];
    assign s_target    = 35'(s_reward_sh) + 35'(s_gshift);
    assign s_diff      = DW'(s_target) - DW'(r_q);
    assign s_aprod     = APW'(s_alpha) * APW'(r_diff);
    assign s_nv        = NVW'(r_aprod[APW-1:16]) + NVW'(r_q);

    always_comb begin
        if (s_nv > NVW'(38'sd2147483647)) begin
            s_nv_sat = {1'b0, {(QW-1){1'b1}}};
        end else if (s_nv < -NVW'(38'sd2147483648)) begin
            s_nv_sat = {1'b1, {(QW-1){1'b0}}};
        end else begin
            s_nv_sat = s_nv[QW-1:0];
        end
    end

    // write-back of the updated row, or a zero row during the clearing pass
    always_comb begin
        s_wr_en   = (r_state == S_CLR) || (r_state == S_SAT);
        s_wr_addr = (r_state == S_CLR) ? r_clr_addr : r_st;
        s_wr_data = s_row_a;
        s_wr_data[r_act*QW +: QW] = s_nv_sat;
        if (r_state == S_CLR) begin
            s_wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(STATES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_cmd     <= i_command;
                        r_st      <= s_addr_a;
                        r_act     <= f_action_mod(i_action_index);
                        r_ract    <= f_action_mod(i_random_action);
                        r_reward  <= i_reward;
                        r_explore <= ({1'b0, i_random_draw} < s_cfg.exploration_rate);
                        r_state   <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_q     <= s_row_a[r_act*QW +: QW];
                    r_state <= S_GMUL;
                end
                S_GMUL: begin
                    if (r_cmd == qlte_pkg::CMD_CHOOSE) begin
                        r_done     <= 1'b1;
                        r_chosen   <= r_explore ? 3'(r_ract) : s_idx;
                        r_explored <= r_explore;
                        r_new_q    <= s_max;
                        r_state    <= S_IDLE;
                    end else begin
                        r_gprod <= s_gprod;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_diff  <= s_diff;
                    r_state <= S_AMUL;
                end
                S_AMUL: begin
                    r_aprod <= s_aprod;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_done     <= 1'b1;
                    r_chosen   <= 3'd0;
                    r_explored <= 1'b0;
                    r_new_q    <= s_nv_sat;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_chosen_action = r_chosen;
    assign o_explored      = r_explored;
    assign o_new_q_value   = r_new_q;

endmodule

`default_nettype wire

// File: hw/rtl/qlte_checker.sv
// Port-level checker for the Q table engine, bound to the top level.
// Depends on q_learning_table_engine_unit_assert.svh.
`default_nettype none

`include "q_learning_table_engine_unit_assert.svh"

module qlte_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done
);

    `QLTE_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
    `QLTE_ASSERT_NOW(a_done_when_idle, o_done, !busy)
    `QLTE_ASSERT_NEXT(a_single_word, o_done, !o_done)
    `QLTE_ASSERT_NOW(a_busy_from_accept, $rose(busy), $past(start))

endmodule

bind q_learning_table_engine_unit qlte_checker u_qlte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done)
);

`default_nettype wire
